FILE: hw/rtl/swtcp_pkg.sv
// Shared types and constants for the tunnel stream deframer.
// No dependencies; imported by every module of the block.
package swtcp_pkg;

    localparam int unsigned CFG_COUNT  = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMPLETE_EOP  = 3'd0,
        CFG_COMPLETE_EEP  = 3'd1,
        CFG_FRAGMENT      = 3'd2,
        CFG_SEND_TIMECODE = 3'd3,
        CFG_GOT_TIMECODE  = 3'd4
    } cfg_index_t;

    localparam logic [7:0] RST_COMPLETE_EOP  = 8'd0;
    localparam logic [7:0] RST_COMPLETE_EEP  = 8'd1;
    localparam logic [7:0] RST_FRAGMENT      = 8'd2;
    localparam logic [7:0] RST_SEND_TIMECODE = 8'd48;
    localparam logic [7:0] RST_GOT_TIMECODE  = 8'd49;

    // header: flag, reserved, ten size bytes
    localparam logic [3:0] HEADER_LAST = 4'd11;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_END    = 3'd1,
        KIND_CMD    = 3'd2,
        KIND_NOTICE = 3'd3,
        KIND_BAD    = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_DATA    = 4'b0010,
        PH_CONTROL = 4'b0100,
        PH_HALT    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] flag_complete_eop;
        logic [7:0] flag_complete_eep;
        logic [7:0] flag_fragment;
        logic [7:0] flag_send_timecode;
        logic [7:0] flag_got_timecode;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
        logic       error_end;
    } result_t;

endpackage

FILE: hw/rtl/swtcp_in_if.sv
// Byte stream channel: valid/ready handshake carrying one stream byte.
// No dependencies.
interface swtcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: hw/rtl/swtcp_out_if.sv
// Result channel: valid/ready handshake carrying one deframer result.
// No dependencies.
interface swtcp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
    logic       error_end;

    modport source (output valid, output kind, output value, output last,
                    output error_end, input ready);
    modport sink   (input valid, input kind, input value, input last,
                    input error_end, output ready);
endinterface

FILE: hw/rtl/swtcp_cfg_regs.sv
// Flag code registers written through the plain write port.
// Depends on swtcp_pkg.
module swtcp_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [swtcp_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [swtcp_pkg::CFG_DATA_W-1:0]      wr_data,
    output swtcp_pkg::cfg_t                       cfg
);
    import swtcp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_COMPLETE_EOP:  cfg_next.flag_complete_eop  = wr_data;
                CFG_COMPLETE_EEP:  cfg_next.flag_complete_eep  = wr_data;
                CFG_FRAGMENT:      cfg_next.flag_fragment      = wr_data;
                CFG_SEND_TIMECODE: cfg_next.flag_send_timecode = wr_data;
                CFG_GOT_TIMECODE:  cfg_next.flag_got_timecode  = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_complete_eop  <= RST_COMPLETE_EOP;
            cfg_reg.flag_complete_eep  <= RST_COMPLETE_EEP;
            cfg_reg.flag_fragment      <= RST_FRAGMENT;
            cfg_reg.flag_send_timecode <= RST_SEND_TIMECODE;
            cfg_reg.flag_got_timecode  <= RST_GOT_TIMECODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/swtcp_parser.sv
// Frame parser: header/data/control/halt state and per-byte result logic.
// Depends on swtcp_pkg.
module swtcp_parser #(
    parameter int unsigned SIZE_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_take,
    input  logic [7:0]           in_byte,
    input  swtcp_pkg::cfg_t      cfg,
    output logic                 res_valid,
    output swtcp_pkg::result_t   res
);
    import swtcp_pkg::*;

    localparam logic [SIZE_BITS-1:0] SIZE_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    phase_t                 phase_reg,           phase_next;
    logic [3:0]             header_count_reg,    header_count_next;
    logic [7:0]             frame_flag_reg,      frame_flag_next;
    logic [SIZE_BITS-1:0]   bytes_left_reg,      bytes_left_next;
    logic                   control_count_reg,   control_count_next;
    logic                   packet_has_data_reg, packet_has_data_next;
    logic [7:0]             stored_timecode_reg, stored_timecode_next;

    logic is_complete;
    logic is_eep;
    logic is_fragment;
    logic is_send;
    logic is_got;

    // flag is latched on the first header byte; it is only decoded later
    assign is_eep      = frame_flag_reg == cfg.flag_complete_eep;
    assign is_complete = (frame_flag_reg == cfg.flag_complete_eop) || is_eep;
    assign is_fragment = frame_flag_reg == cfg.flag_fragment;
    assign is_send     = frame_flag_reg == cfg.flag_send_timecode;
    assign is_got      = frame_flag_reg == cfg.flag_got_timecode;

    always_comb
    begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        frame_flag_next      = frame_flag_reg;
        bytes_left_next      = bytes_left_reg;
        control_count_next   = control_count_reg;
        packet_has_data_next = packet_has_data_reg;
        stored_timecode_next = stored_timecode_reg;
        res_valid            = 1'b0;
        res.kind             = KIND_DATA;
        res.value            = in_byte;
        res.last             = 1'b0;
        res.error_end        = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (header_count_reg == 4'd0)
                begin
                    frame_flag_next = in_byte;
                    bytes_left_next = '0;
                end
                else if (header_count_reg >= 4'd2)
                begin
                    bytes_left_next = {bytes_left_reg[SIZE_BITS-9:0], in_byte};
                end
                header_count_next = header_count_reg + 4'd1;
                if (header_count_reg == HEADER_LAST)
                begin
                    header_count_next = 4'd0;
                    if (is_complete || is_fragment)
                    begin
                        if (bytes_left_next != '0)
                        begin
                            phase_next = PH_DATA;
                        end
                        else if (is_complete && packet_has_data_reg)
                        begin
                            packet_has_data_next = 1'b0;
                            res_valid            = 1'b1;
                            res.kind             = KIND_END;
                            res.value            = 8'd0;
                            res.last             = 1'b1;
                            res.error_end        = is_eep;
                        end
                    end
                    else if (is_send || is_got)
                    begin
                        phase_next         = PH_CONTROL;
                        control_count_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res.kind   = KIND_BAD;
                        res.value  = frame_flag_reg;
                    end
                end
            end
            PH_DATA:
            begin
                bytes_left_next      = bytes_left_reg - SIZE_ONE;
                packet_has_data_next = 1'b1;
                res_valid            = 1'b1;
                if (bytes_left_next == '0)
                begin
                    phase_next = PH_HEADER;
                    if (is_complete)
                    begin
                        packet_has_data_next = 1'b0;
                        res.last             = 1'b1;
                        res.error_end        = is_eep;
                    end
                end
            end
            PH_CONTROL:
            begin
                if (!control_count_reg)
                begin
                    stored_timecode_next = in_byte;
                    control_count_next   = 1'b1;
                end
                else
                begin
                    control_count_next = 1'b0;
                    phase_next         = PH_HEADER;
                    res_valid          = 1'b1;
                    res.value          = stored_timecode_reg;
                    if (is_send)
                    begin
                        packet_has_data_next = 1'b0;
                        res.kind             = KIND_CMD;
                    end
                    else
                    begin
                        res.kind = KIND_NOTICE;
                    end
                end
            end
            PH_HALT:
            begin
                phase_next = PH_HALT;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HEADER;
            header_count_reg    <= 4'd0;
            frame_flag_reg      <= 8'd0;
            bytes_left_reg      <= '0;
            control_count_reg   <= 1'b0;
            packet_has_data_reg <= 1'b0;
            stored_timecode_reg <= 8'd0;
        end
        else if (in_take)
        begin
            phase_reg           <= phase_next;
            header_count_reg    <= header_count_next;
            frame_flag_reg      <= frame_flag_next;
            bytes_left_reg      <= bytes_left_next;
            control_count_reg   <= control_count_next;
            packet_has_data_reg <= packet_has_data_next;
            stored_timecode_reg <= stored_timecode_next;
        end
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("parser left halt state");

    a_header_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= HEADER_LAST)
        else $error("header byte count out of range");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("data phase with no bytes left");

    a_bad_flag_halts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && res_valid && res.kind == KIND_BAD |=> phase_reg == PH_HALT)
        else $error("bad flag reported without halting");

endmodule

FILE: hw/rtl/swtcp_out_reg.sv
// Result register between the parser and the result channel.
// Depends on swtcp_pkg and swtcp_out_if.
module swtcp_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  swtcp_pkg::result_t   push_data,
    output logic                 space,
    swtcp_out_if.source          result
);
    import swtcp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    assign space = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (push)
        begin
            valid_next = 1'b1;
            data_next  = push_data;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result.valid     = valid_reg;
    assign result.kind      = data_reg.kind;
    assign result.value     = data_reg.value;
    assign result.last      = data_reg.last;
    assign result.error_end = data_reg.error_end;

    a_err_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.last || !data_reg.error_end))
        else $error("error end without end of packet");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !result.ready |=> valid_reg && $stable(data_reg))
        else $error("pending result overwritten");

endmodule

FILE: hw/rtl/spacewire_tcp_deframer.sv
// Tunnel stream deframer, top level.
// Depends on swtcp_pkg, swtcp_in_if, swtcp_out_if, swtcp_cfg_regs,
// swtcp_parser and swtcp_out_reg.
//
// Usage:
//  stream : one byte of the tunnel stream per transaction (valid/ready).
//  result : zero or one result per input byte: data byte, end-only marker,
//           timecode command, timecode notice or bad flag.
//  wr_en/wr_index/wr_data : flag code registers 0..4, written while idle;
//           indexes beyond 4 are ignored.
//  Throughput: one byte per cycle unless a stalled receiver holds a
//  result. The parser state advances in the cycle a byte is taken and
//  its result enters the single output register, seen in the cycle after.
//  stream.ready is high whenever the output register is empty or is being
//  drained in the same cycle; a stalled receiver holds the result and
//  backs pressure up to the stream side with no loss.
//  Reset: parser returns to the header phase, output register empties and
//  the flag codes take their defaults. After a bad flag the block discards
//  every byte until the next reset.
module spacewire_tcp_deframer #(
    parameter int unsigned SIZE_BITS = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    swtcp_in_if.sink                              stream,
    swtcp_out_if.source                           result,
    input  logic                                  wr_en,
    input  logic [swtcp_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [swtcp_pkg::CFG_DATA_W-1:0]      wr_data
);
    import swtcp_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    res_valid;
    logic    space;
    logic    take;

    assign stream.ready = space;
    assign take         = stream.valid && space;

    swtcp_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    swtcp_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (take),
        .in_byte   (stream.in_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    swtcp_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_valid),
        .push_data (res),
        .space     (space),
        .result    (result)
    );

endmodule

FILE: tb/spacewire_tcp_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the tunnel stream deframer: frames of random content under
// several flag code settings, with random stalls on both channels, checked per result.
// Depends on swtcp_pkg, swtcp_in_if, swtcp_out_if and spacewire_tcp_deframer.
module spacewire_tcp_deframer_tb;
    import swtcp_pkg::*;

    localparam int unsigned SIZE_BITS     = 32;
    localparam int unsigned SIZE_FIELD    = 10;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_BYTES  = 1000;
    localparam int unsigned SETTING_COUNT = 8;
    localparam int unsigned PRINT_CAP     = 50;

    typedef logic [CFG_IDX_W-1:0] reg_index_t;
    typedef enum {FRAME_DATA, FRAME_CONTROL, FRAME_BAD} frame_class_t;
    typedef enum {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

    class deframer_scoreboard;
        logic [7:0]           flag_code [CFG_COUNT];
        phase_t               phase;
        logic [3:0]           header_count;
        logic [7:0]           frame_flag;
        logic [SIZE_BITS-1:0] bytes_left;
        logic                 control_count;
        logic                 packet_has_data;
        logic [7:0]           stored_timecode;
        result_t              pending_results [$];
        int unsigned          bytes_taken;
        int unsigned          kind_seen [KIND_BAD + 1];
        int unsigned          mismatches;

        function new();
            flag_code[CFG_COMPLETE_EOP]  = RST_COMPLETE_EOP;
            flag_code[CFG_COMPLETE_EEP]  = RST_COMPLETE_EEP;
            flag_code[CFG_FRAGMENT]      = RST_FRAGMENT;
            flag_code[CFG_SEND_TIMECODE] = RST_SEND_TIMECODE;
            flag_code[CFG_GOT_TIMECODE]  = RST_GOT_TIMECODE;
            phase           = PH_HEADER;
            header_count    = '0;
            frame_flag      = '0;
            bytes_left      = '0;
            control_count   = 1'b0;
            packet_has_data = 1'b0;
            stored_timecode = '0;
            bytes_taken     = 0;
            mismatches      = 0;
            foreach (kind_seen[k])
                kind_seen[k] = 0;
        endfunction

        function void write_flag(reg_index_t idx, logic [7:0] data);
            if (idx < CFG_COUNT)
                flag_code[idx] = data;
        endfunction

        function frame_class_t classify(logic [7:0] flag);
            if (flag == flag_code[CFG_COMPLETE_EOP] || flag == flag_code[CFG_COMPLETE_EEP] ||
                flag == flag_code[CFG_FRAGMENT])
                return FRAME_DATA;
            if (flag == flag_code[CFG_SEND_TIMECODE] || flag == flag_code[CFG_GOT_TIMECODE])
                return FRAME_CONTROL;
            return FRAME_BAD;
        endfunction

        function bit is_complete();
            return frame_flag == flag_code[CFG_COMPLETE_EOP] ||
                   frame_flag == flag_code[CFG_COMPLETE_EEP];
        endfunction

        function void push_result(kind_t k, logic [7:0] v, logic l, logic e);
            result_t r;
            r.kind      = k;
            r.value     = v;
            r.last      = l;
            r.error_end = e;
            pending_results.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            bytes_taken++;
            case (phase)
                PH_HEADER:
                begin
                    if (header_count == 0)
                    begin
                        frame_flag = b;
                        bytes_left = '0;
                    end
                    else if (header_count >= 2)
                        bytes_left = {bytes_left[SIZE_BITS-9:0], b};
                    if (header_count != HEADER_LAST)
                        header_count++;
                    else
                    begin
                        header_count = '0;
                        case (classify(frame_flag))
                            FRAME_DATA:
                            begin
                                if (bytes_left != 0)
                                    phase = PH_DATA;
                                else if (is_complete() && packet_has_data)
                                begin
                                    packet_has_data = 1'b0;
                                    push_result(KIND_END, 8'h00, 1'b1,
                                                frame_flag == flag_code[CFG_COMPLETE_EEP]);
                                end
                            end
                            FRAME_CONTROL:
                            begin
                                phase         = PH_CONTROL;
                                control_count = 1'b0;
                            end
                            default:
                            begin
                                phase = PH_HALT;
                                push_result(KIND_BAD, frame_flag, 1'b0, 1'b0);
                            end
                        endcase
                    end
                end
                PH_DATA:
                begin
                    bytes_left      = bytes_left - 1'b1;
                    packet_has_data = 1'b1;
                    if (bytes_left != 0)
                        push_result(KIND_DATA, b, 1'b0, 1'b0);
                    else
                    begin
                        phase = PH_HEADER;
                        if (is_complete())
                        begin
                            packet_has_data = 1'b0;
                            push_result(KIND_DATA, b, 1'b1,
                                        frame_flag == flag_code[CFG_COMPLETE_EEP]);
                        end
                        else
                            push_result(KIND_DATA, b, 1'b0, 1'b0);
                    end
                end
                PH_CONTROL:
                begin
                    if (!control_count)
                    begin
                        stored_timecode = b;
                        control_count   = 1'b1;
                    end
                    else
                    begin
                        control_count = 1'b0;
                        phase         = PH_HEADER;
                        if (frame_flag == flag_code[CFG_SEND_TIMECODE])
                        begin
                            packet_has_data = 1'b0;
                            push_result(KIND_CMD, stored_timecode, 1'b0, 1'b0);
                        end
                        else
                            push_result(KIND_NOTICE, stored_timecode, 1'b0, 1'b0);
                    end
                end
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d value %02h", got.kind, got.value));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
            if (got.value !== want.value)
                report($sformatf("value %02h, wanted %02h (kind %0d)", got.value, want.value,
                                 want.kind));
            if (got.last !== want.last)
                report($sformatf("last %b, wanted %b", got.last, want.last));
            if (got.error_end !== want.error_end)
                report($sformatf("error_end %b, wanted %b", got.error_end, want.error_end));
            kind_seen[want.kind]++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    reg_index_t  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    swtcp_in_if  stream_ch ();
    swtcp_out_if result_ch ();

    deframer_scoreboard sb = new();
    idle_mode_t  sender_mode   = IDLE_FULL;
    idle_mode_t  receiver_mode = IDLE_FULL;
    int unsigned cycle_count   = 0;
    int unsigned frames_sent   = 0;

    spacewire_tcp_deframer #(.SIZE_BITS(SIZE_BITS)) uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     sb.pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic int unsigned idle_draw(idle_mode_t mode);
        case (mode)
            IDLE_FULL:   return $urandom_range(0, 13);
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
            default:     return 0;
        endcase
    endfunction

    // result sink with random back-pressure
    initial
    begin
        int unsigned stall;
        result_t     got;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_draw(receiver_mode);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            got.kind      = result_ch.kind;
            got.value     = result_ch.value;
            got.last      = result_ch.last;
            got.error_end = result_ch.error_end;
            sb.check_result(got);
        end
    end

    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = idle_draw(sender_mode);
        if (gap > 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid   <= 1'b1;
        stream_ch.in_byte <= b;
        do @(posedge clk); while (stream_ch.ready !== 1'b1);
        sb.note_byte(b);
    endtask

    task automatic send_header(logic [7:0] flag, logic [SIZE_BITS-1:0] size, bit overflow);
        send_byte(flag);
        send_byte(8'($urandom_range(0, 255)));
        repeat (SIZE_FIELD - SIZE_BITS / 8)
            send_byte(overflow ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = SIZE_BITS / 8 - 1; i >= 0; i--)
            send_byte(size[8*i +: 8]);
        frames_sent++;
    endtask

    task automatic send_frame(logic [7:0] flag, logic [SIZE_BITS-1:0] size, bit overflow);
        frame_class_t cls;
        cls = sb.classify(flag);
        send_header(flag, size, overflow);
        if (cls == FRAME_CONTROL)
            repeat (2) send_byte(8'($urandom_range(0, 255)));
        else if (cls == FRAME_DATA)
            repeat (size) send_byte(8'($urandom_range(0, 255)));
    endtask

    // hold the stream until every outstanding result has been taken
    task automatic drain_results();
        stream_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic write_register(reg_index_t idx, logic [7:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en    <= 1'b0;
        sb.write_flag(idx, data);
    endtask

    task automatic apply_setting(int unsigned setting);
        logic [7:0] codes [CFG_COUNT];
        logic [7:0] shared;
        shared = 8'($urandom_range(0, 255));
        foreach (codes[i])
            codes[i] = 8'($urandom_range(0, 255));
        case (setting)
            0:
            begin
                codes[CFG_COMPLETE_EOP]  = RST_COMPLETE_EOP;
                codes[CFG_COMPLETE_EEP]  = RST_COMPLETE_EEP;
                codes[CFG_FRAGMENT]      = RST_FRAGMENT;
                codes[CFG_SEND_TIMECODE] = RST_SEND_TIMECODE;
                codes[CFG_GOT_TIMECODE]  = RST_GOT_TIMECODE;
            end
            1:
            begin
                codes[CFG_COMPLETE_EOP]  = 8'hFF;
                codes[CFG_COMPLETE_EEP]  = 8'h00;
                codes[CFG_FRAGMENT]      = 8'h80;
                codes[CFG_SEND_TIMECODE] = 8'h7F;
                codes[CFG_GOT_TIMECODE]  = 8'h01;
            end
            2:
            begin
                codes[CFG_COMPLETE_EOP] = shared;
                codes[CFG_COMPLETE_EEP] = shared;
            end
            3:
            begin
                codes[CFG_FRAGMENT]      = codes[CFG_COMPLETE_EOP];
                codes[CFG_GOT_TIMECODE]  = codes[CFG_SEND_TIMECODE];
            end
            4:
                codes[CFG_SEND_TIMECODE] = codes[CFG_FRAGMENT];
            6:
                foreach (codes[i])
                    codes[i] = 8'hFF;
            7:
                foreach (codes[i])
                    codes[i] = 8'h00;
            default:
                ;
        endcase
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < CFG_COUNT; i++)
            write_register(reg_index_t'(i), codes[i]);
        write_register(reg_index_t'(CFG_COUNT + $urandom_range(0, 2)),
                       8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_frames(int unsigned budget);
        int unsigned start;
        int unsigned pick;
        logic [7:0]  flag;
        logic [SIZE_BITS-1:0] size;
        start = sb.bytes_taken;
        while (sb.bytes_taken - start < budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                flag = sb.flag_code[CFG_COMPLETE_EOP];
            else if (pick < 4)
                flag = sb.flag_code[CFG_COMPLETE_EEP];
            else if (pick < 7)
                flag = sb.flag_code[CFG_FRAGMENT];
            else if (pick < 9)
                flag = sb.flag_code[CFG_SEND_TIMECODE];
            else
                flag = sb.flag_code[CFG_GOT_TIMECODE];
            pick = $urandom_range(0, 19);
            if (pick < 3)
                size = 0;
            else if (pick < 15)
                size = $urandom_range(1, 8);
            else if (pick < 19)
                size = $urandom_range(9, 40);
            else
                size = $urandom_range(41, 300);
            send_frame(flag, size, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        logic [7:0] bad_flag;
        rst_n             <= 1'b0;
        wr_en             <= 1'b0;
        wr_index          <= CFG_COMPLETE_EOP;
        wr_data           <= '0;
        stream_ch.valid   <= 1'b0;
        stream_ch.in_byte <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames on the reset flag codes
        send_header(RST_COMPLETE_EOP, 0, 1'b0);
        send_header(RST_FRAGMENT, 2, 1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(RST_SEND_TIMECODE, 0, 1'b1);
        send_byte(8'hAA);
        send_byte(8'h00);
        // packet abandoned by the command: no end marker
        send_header(RST_COMPLETE_EOP, 0, 1'b0);
        send_header(RST_FRAGMENT, 1, 1'b0);
        send_byte(8'h55);
        send_header(RST_COMPLETE_EEP, 0, 1'b0);
        send_header(RST_GOT_TIMECODE, 0, 1'b0);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_header(RST_COMPLETE_EOP, 1, 1'b1);
        send_byte(8'hFF);
        send_header(RST_COMPLETE_EEP, 2, 1'b0);
        send_byte(8'h01);
        send_byte(8'h80);
        send_header(RST_FRAGMENT, 0, 1'b0);
        send_frame(RST_COMPLETE_EOP, 256, 1'b0);

        for (int s = 0; s < SETTING_COUNT; s++)
        begin
            sender_mode   = idle_mode_t'(s % 3);
            receiver_mode = idle_mode_t'((s + 1) % 3);
            apply_setting(s);
            send_random_frames(RANDOM_BYTES / SETTING_COUNT);
        end

        // unknown flag halts the parser; trailing bytes must be dropped
        sender_mode = IDLE_SPARSE;
        do bad_flag = 8'($urandom_range(0, 255)); while (sb.classify(bad_flag) != FRAME_BAD);
        send_header(bad_flag, 0, 1'b0);
        repeat (20) send_byte(8'($urandom_range(0, 255)));

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d stream bytes in %0d frames over %0d flag code settings",
                 sb.bytes_taken, frames_sent, SETTING_COUNT + 1);
        $display("results: %0d data, %0d end-only, %0d command, %0d notice, %0d bad flag",
                 sb.kind_seen[KIND_DATA], sb.kind_seen[KIND_END], sb.kind_seen[KIND_CMD],
                 sb.kind_seen[KIND_NOTICE], sb.kind_seen[KIND_BAD]);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/swtcp_pkg.sv
hw/rtl/swtcp_in_if.sv
hw/rtl/swtcp_out_if.sv
hw/rtl/swtcp_cfg_regs.sv
hw/rtl/swtcp_parser.sv
hw/rtl/swtcp_out_reg.sv
hw/rtl/spacewire_tcp_deframer.sv
tb/spacewire_tcp_deframer_tb.sv
